>>> rtl/omr_pkg.sv
package omr_pkg;

   localparam int SLOTS     = 8;
   localparam int MSG_BYTES = 64;

   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int IDX_W     = $clog2(MSG_BYTES);
   localparam int MEM_DEPTH = SLOTS * MSG_BYTES;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int ACTION_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int LIMIT_W   = 7;
   localparam int STATUS_W  = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_DROPPED  = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_DEQUEUED = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_BYTE     = 3'd5,
      ST_REFUSED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_COPY,
      FSM_STREAM
   } fsm_state_type;

   typedef struct packed {
      logic write_byte;
      logic tick_empty;
      logic copy_start;
      logic copy_run;
      logic copy_finish;
      logic read_refuse;
      logic stream_start;
      logic stream_run;
   } dp_cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic read_bad;
      logic space;
      logic copy_done;
      logic stream_last;
   } dp_status_type;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
   } result_type;

endpackage

>>> rtl/omr_ctrl.sv
module omr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [omr_pkg::ACTION_W-1:0]   req_action,
   input  omr_pkg::dp_status_type         status,
   output logic                           req_stall,
   output omr_pkg::dp_cmd_type            cmd
);
   import omr_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          accept;
   action_type    action;

   assign action    = action_type'(req_action);
   assign req_stall = (state_ff != FSM_IDLE) || !status.space;
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && action == ACT_TICK && !status.ring_empty) begin
               state_in = FSM_COPY;
            end else if (accept && action == ACT_READ && !status.read_bad) begin
               state_in = FSM_STREAM;
            end
         end
         FSM_COPY: begin
            if (status.copy_done && status.space) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_STREAM: begin
            if (status.stream_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_WRITE: cmd.write_byte = 1'b1;
                  ACT_TICK: begin
                     cmd.tick_empty = status.ring_empty;
                     cmd.copy_start = !status.ring_empty;
                  end
                  ACT_READ: begin
                     cmd.read_refuse  = status.read_bad;
                     cmd.stream_start = !status.read_bad;
                  end
                  default: ;
               endcase
            end
         end
         FSM_COPY: begin
            cmd.copy_run    = 1'b1;
            cmd.copy_finish = status.copy_done && status.space;
         end
         FSM_STREAM: begin
            cmd.stream_run = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/omr_datapath.sv
module omr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  omr_pkg::dp_cmd_type            cmd,
   input  logic [omr_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_final_byte,
   input  logic [omr_pkg::LIMIT_W-1:0]    req_read_limit,
   input  logic                           rsp_stall,
   output omr_pkg::dp_status_type         status,
   output logic                           rsp_valid,
   output logic [omr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [omr_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_out_last
);
   import omr_pkg::*;

   logic [BYTE_W-1:0] slot_mem [MEM_DEPTH];
   logic [BYTE_W-1:0] kept_mem [MSG_BYTES];
   logic [IDX_W-1:0]  slot_len_ff [SLOTS];

   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0]  fill_ff, fill_in, kept_len_ff, kept_len_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in, len_ff, len_in, widx_ff, widx_in;
   logic              over_ff, over_in, pend_ff, pend_in;
   logic              spend_ff, spend_in, slast_ff, slast_in;
   logic [BYTE_W-1:0] slot_rd_ff, kept_rd_ff;
   result_type        q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]        qcnt_ff, qcnt_in;

   logic [SLOT_W-1:0] head_next, tail_next;
   logic [IDX_W-1:0]  fill_inc, cnt_inc;
   logic [MEM_AW-1:0] wr_addr, rd_addr;
   logic              room, too_long, drop, commit;
   logic              copy_issue, stream_issue, push_byte, space;
   logic              push, pop;
   result_type        push_res;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
      next_slot = (i == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(i + 1'b1);
   endfunction

   assign head_next = next_slot(head_ff);
   assign tail_next = next_slot(tail_ff);
   assign fill_inc  = IDX_W'(fill_ff + 1'b1);
   assign cnt_inc   = IDX_W'(cnt_ff + 1'b1);
   assign wr_addr   = MEM_AW'(MEM_AW'(tail_ff) * MEM_AW'(MSG_BYTES) + MEM_AW'(fill_ff));
   assign rd_addr   = MEM_AW'(MEM_AW'(head_ff) * MEM_AW'(MSG_BYTES) + MEM_AW'(cnt_ff));

   assign room     = fill_ff != IDX_W'(MSG_BYTES - 1);
   assign too_long = over_ff || !room;
   assign drop     = tail_next == head_ff;
   assign commit   = cmd.write_byte && req_final_byte && !too_long;

   assign space        = qcnt_ff != 2'd2;
   assign pop          = (qcnt_ff != 2'd0) && !rsp_stall;
   assign copy_issue   = cmd.copy_run && (cnt_ff != len_ff);
   assign push_byte    = cmd.stream_run && spend_ff && space;
   assign stream_issue = cmd.stream_run && (cnt_ff != kept_len_ff)
                         && (!spend_ff || push_byte);

   assign status.ring_empty  = head_ff == tail_ff;
   assign status.read_bad    = (kept_len_ff == '0)
                               || (req_read_limit < LIMIT_W'(kept_len_ff));
   assign status.space       = space;
   assign status.copy_done   = (cnt_ff == len_ff) && !pend_ff;
   assign status.stream_last = push_byte && slast_ff;

   // result select: at most one source pushes in a cycle
   always_comb begin
      push     = 1'b1;
      push_res = '{status: ST_ACCEPTED, out_byte: '0, out_last: 1'b1};
      if (cmd.write_byte && req_final_byte) begin
         if (too_long) begin
            push_res.status = ST_TOO_LONG;
         end else if (drop) begin
            push_res.status = ST_DROPPED;
         end
      end else if (cmd.tick_empty) begin
         push_res.status = ST_EMPTY;
      end else if (cmd.read_refuse) begin
         push_res.status = ST_REFUSED;
      end else if (cmd.copy_finish) begin
         push_res.status = ST_DEQUEUED;
      end else if (push_byte) begin
         push_res = '{status: ST_BYTE, out_byte: kept_rd_ff, out_last: slast_ff};
      end else begin
         push = 1'b0;
      end
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      over_in     = over_ff;
      kept_len_in = kept_len_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      widx_in     = widx_ff;
      pend_in     = 1'b0;
      spend_in    = spend_ff;
      slast_in    = slast_ff;

      if (cmd.write_byte) begin
         if (room) begin
            fill_in = fill_inc;
         end else begin
            over_in = 1'b1;
         end
         if (req_final_byte) begin
            fill_in = '0;
            over_in = 1'b0;
            if (!too_long) begin
               tail_in = tail_next;
               if (drop) begin
                  head_in = head_next;
               end
            end
         end
      end

      if (cmd.copy_start) begin
         cnt_in = '0;
         len_in = slot_len_ff[head_ff];
      end
      if (copy_issue) begin
         pend_in = 1'b1;
         cnt_in  = cnt_inc;
         widx_in = cnt_ff;
      end
      if (cmd.copy_finish) begin
         head_in     = head_next;
         kept_len_in = len_ff;
      end

      if (cmd.stream_start) begin
         cnt_in   = '0;
         spend_in = 1'b0;
      end
      if (stream_issue) begin
         cnt_in   = cnt_inc;
         spend_in = 1'b1;
         slast_in = cnt_inc == kept_len_ff;
      end else if (push_byte) begin
         spend_in = 1'b0;
      end
   end

   // two-entry result queue
   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff;
      if (pop) begin
         q0_in   = q1_ff;
         qcnt_in = qcnt_ff - 2'd1;
      end
      if (push) begin
         if (qcnt_in == 2'd0) begin
            q0_in = push_res;
         end else begin
            q1_in = push_res;
         end
         qcnt_in = qcnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         over_ff     <= 1'b0;
         kept_len_ff <= '0;
         cnt_ff      <= '0;
         len_ff      <= '0;
         pend_ff     <= 1'b0;
         spend_ff    <= 1'b0;
         slast_ff    <= 1'b0;
         qcnt_ff     <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         over_ff     <= over_in;
         kept_len_ff <= kept_len_in;
         cnt_ff      <= cnt_in;
         len_ff      <= len_in;
         pend_ff     <= pend_in;
         spend_ff    <= spend_in;
         slast_ff    <= slast_in;
         qcnt_ff     <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
      if (commit) begin
         slot_len_ff[tail_ff] <= fill_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte && room) begin
         slot_mem[wr_addr] <= req_data_byte;
      end
      if (copy_issue) begin
         slot_rd_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         kept_mem[widx_ff] <= slot_rd_ff;
      end
      if (stream_issue) begin
         kept_rd_ff <= kept_mem[cnt_ff];
      end
   end

   assign rsp_valid    = qcnt_ff != 2'd0;
   assign rsp_status   = q0_ff.status;
   assign rsp_out_byte = q0_ff.out_byte;
   assign rsp_out_last = q0_ff.out_last;

endmodule

>>> rtl/overwriting_message_ring_top.sv
// Overwriting message ring.
// Request channel (req_*): one beat carries an action and its operands.
//   write: one message byte per beat, req_final_byte commits the message and
//   returns one status beat (accepted, accepted dropping oldest, too long).
//   tick: moves the oldest queued message to the kept store and returns one
//   status beat (dequeued or empty).
//   read: streams the kept message, one rsp beat per byte, rsp_out_last on
//   the last one, or returns a single refused beat.
// Response channel (rsp_*): status, byte and last flag per beat, from a
//   two-entry output queue, so a waiting beat does not block the next request.
// Result timing: a final write byte, an empty tick or a refused read shows up in
//   the cycle after its request beat if no beat waits; a dequeued beat once every
//   slot byte is copied (one slot byte copied a cycle) and the queue has room.
// Flow: write bytes go at one per cycle while the output queue has room; a tick
//   that dequeues or a streamed read holds requests until its last beat is queued.
// Reset: ring empty, nothing kept; message memories need no clearing pass.
// Receiver stall: the output queue fills, then the stream and the request
//   channel hold until a beat is taken.
module overwriting_message_ring_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [omr_pkg::ACTION_W-1:0]   req_action,
   input  logic [omr_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_final_byte,
   input  logic [omr_pkg::LIMIT_W-1:0]    req_read_limit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [omr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [omr_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_out_last
);
   import omr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence each request: byte writes in the cycle they are accepted, copy and stream loops
   omr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // hold ring pointers, slot and kept memories, and the output queue
   omr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_read_limit (req_read_limit),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

>>> tb/overwriting_message_ring_top_test.sv
module overwriting_message_ring_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import omr_pkg::*;

   // Give up well past the slowest correct run: a few hundred request beats,
   // reads of up to 63 bytes each, every beat held by random stalls.
   localparam int CYCLE_LIMIT = 400000;
   // Longest quiet stretch the block needs: a full tick copy plus slack.
   localparam int SETTLE_CYCLES = MSG_BYTES + 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action     = ACT_NONE;
   logic [BYTE_W-1:0]   req_data_byte  = '0;
   logic                req_final_byte = 1'b0;
   logic [LIMIT_W-1:0]  req_read_limit = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_last;

   overwriting_message_ring_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_read_limit (req_read_limit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the ring: queued slots, the message being gathered and
   // the kept (last dequeued) message.
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0]  ring_data [SLOTS][MSG_BYTES];
   logic [LIMIT_W-1:0] ring_len  [SLOTS];
   logic [SLOT_W-1:0]  oldest_slot = '0;
   logic [SLOT_W-1:0]  fill_slot   = '0;
   logic [LIMIT_W-1:0] gathered    = '0;
   logic               overlong    = 1'b0;
   logic [BYTE_W-1:0]  kept_data [MSG_BYTES];
   logic [LIMIT_W-1:0] kept_len    = '0;

   result_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int beats_sent    = 0;
   int beats_checked = 0;
   int status_seen [8];

   function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] slot);
      return SLOT_W'((int'(slot) + 1) % SLOTS);
   endfunction

   // Work out the response beats one accepted request beat causes and
   // queue them in order.
   task automatic ring_predict(action_type act, logic [BYTE_W-1:0] data, logic fin,
                               logic [LIMIT_W-1:0] limit);
      result_type beat;
      beat.out_byte = '0;
      beat.out_last = 1'b1;
      case (act)
         ACT_WRITE: begin
            // Store up to MSG_BYTES-1 bytes; anything beyond marks the message overlong.
            if (gathered < MSG_BYTES - 1) begin
               ring_data[fill_slot][gathered[IDX_W-1:0]] = data;
               gathered++;
            end else begin
               overlong = 1'b1;
            end
            if (fin) begin
               if (overlong) begin
                  beat.status = ST_TOO_LONG;
               end else begin
                  // One slot stays free: committing into a full ring drops the oldest.
                  if (slot_after(fill_slot) == oldest_slot) begin
                     oldest_slot = slot_after(oldest_slot);
                     beat.status = ST_DROPPED;
                  end else begin
                     beat.status = ST_ACCEPTED;
                  end
                  ring_len[fill_slot] = gathered;
                  fill_slot = slot_after(fill_slot);
               end
               pending_results.push_back(beat);
               gathered = '0;
               overlong = 1'b0;
            end
         end
         ACT_TICK: begin
            if (oldest_slot == fill_slot) begin
               // Empty ring: the kept message stays as it was.
               beat.status = ST_EMPTY;
            end else begin
               kept_len = ring_len[oldest_slot];
               for (int i = 0; i < kept_len; i++)
                  kept_data[i] = ring_data[oldest_slot][i];
               oldest_slot = slot_after(oldest_slot);
               beat.status = ST_DEQUEUED;
            end
            pending_results.push_back(beat);
         end
         ACT_READ: begin
            if (kept_len == 0 || limit < kept_len) begin
               beat.status = ST_REFUSED;
               pending_results.push_back(beat);
            end else begin
               for (int i = 0; i < kept_len; i++) begin
                  beat.status   = ST_BYTE;
                  beat.out_byte = kept_data[i];
                  beat.out_last = (i == kept_len - 1);
                  pending_results.push_back(beat);
               end
            end
         end
         default: ;   // unused action: no response, nothing changes
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request side: drive at the falling edge, accept at the rising edge.
   // ------------------------------------------------------------------
   task automatic send_beat(action_type act, logic [BYTE_W-1:0] data, logic fin,
                            logic [LIMIT_W-1:0] limit);
      @(negedge clock);
      // Idle for a random number of cycles with garbage on the payload.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_action     <= ACTION_W'($urandom);
         req_data_byte  <= BYTE_W'($urandom);
         req_final_byte <= 1'($urandom);
         req_read_limit <= LIMIT_W'($urandom);
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_data_byte  <= data;
      req_final_byte <= fin;
      req_read_limit <= limit;
      // Hold the beat until the block takes it.
      do @(posedge clock); while (req_stall);
      ring_predict(act, data, fin, limit);
      if (act != ACT_NONE)
         beats_sent++;
   endtask

   // Random byte, biased toward the all-zero and all-one values.
   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hFF;
      return BYTE_W'($urandom);
   endfunction

   // Send a whole message; optionally slip ticks and unused beats between bytes.
   task automatic send_message(int len, bit interleave);
      for (int i = 0; i < len; i++) begin
         if (interleave && $urandom_range(0, 99) < 3)
            send_beat(ACT_TICK, pick_byte(), 1'($urandom), LIMIT_W'($urandom));
         if (interleave && $urandom_range(0, 99) < 3)
            send_beat(ACT_NONE, pick_byte(), 1'($urandom), LIMIT_W'($urandom));
         send_beat(ACT_WRITE, pick_byte(), (i == len - 1), LIMIT_W'($urandom));
      end
   endtask

   task automatic send_read(logic [LIMIT_W-1:0] limit);
      send_beat(ACT_READ, BYTE_W'($urandom), 1'($urandom), limit);
   endtask

   task automatic send_tick();
      send_beat(ACT_TICK, BYTE_W'($urandom), 1'($urandom), LIMIT_W'($urandom));
   endtask

   // Drop valid and hold off the request side until every expected
   // response beat is in.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall, and a checker on every accepted beat.
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $error("unexpected response beat: status %0d out_byte %0h out_last %0b",
                   rsp_status, rsp_out_byte, rsp_out_last);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_out_last !== want.out_last) begin
               $error("out_last: expected %0b, got %0b", want.out_last, rsp_out_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d response beats outstanding",
                  cycle_count, pending_results.size());
         $display("overwriting_message_ring_top test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fresh block: nothing queued, nothing kept.
   task automatic test_after_reset();
      send_tick();
      send_read(7'd64);
      send_read(7'd0);
   endtask

   // A one-byte message of zero value, a three-byte one with a zero in the middle, limits around the length.
   task automatic test_short_messages();
      send_beat(ACT_WRITE, 8'h00, 1'b1, 7'd0);
      send_tick();
      send_read(7'd0);
      send_read(7'd1);
      send_beat(ACT_WRITE, 8'hFF, 1'b0, 7'd0);
      send_beat(ACT_WRITE, 8'h00, 1'b0, 7'd0);
      send_beat(ACT_WRITE, 8'h5A, 1'b1, 7'd0);
      send_tick();
      send_read(7'd2);
      send_read(7'd3);
      // An empty tick keeps the last message readable.
      send_tick();
      send_read(7'd64);
   endtask

   // Longest message that fits, and messages one and three bytes past it.
   task automatic test_length_extremes();
      send_message(MSG_BYTES - 1, 1'b0);
      send_message(MSG_BYTES, 1'b0);
      send_message(MSG_BYTES + 2, 1'b0);
      send_tick();
      send_read(LIMIT_W'(MSG_BYTES - 2));
      send_read(LIMIT_W'(MSG_BYTES - 1));
      send_read(LIMIT_W'(MSG_BYTES));
      wait_drained();
   endtask

   // Overfill the ring so the oldest messages get dropped, then empty it.
   task automatic test_overwrite_oldest();
      for (int i = 0; i < SLOTS + 2; i++)
         send_message(1 + (i % 3), 1'b0);
      for (int i = 0; i < SLOTS; i++) begin
         send_tick();
         send_read(7'd64);
      end
   endtask

   // Unused action code must leave everything alone.
   task automatic test_unused_action();
      send_beat(ACT_NONE, 8'hFF, 1'b1, 7'd127);
      send_beat(ACT_NONE, 8'h00, 1'b0, 7'd0);
      send_read(7'd64);
      send_tick();
   endtask

   // Random traffic: mostly whole messages, plus ticks, reads and noise.
   task automatic test_random_traffic(int beats);
      int start;
      int r;
      int len;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            len = $urandom_range(0, 99);
            if (len < 70)
               len = $urandom_range(1, 6);
            else if (len < 92)
               len = $urandom_range(7, MSG_BYTES - 1);
            else
               len = $urandom_range(MSG_BYTES, MSG_BYTES + 6);
            send_message(len, 1'b1);
         end else if (r < 75) begin
            send_tick();
         end else if (r < 93) begin
            case ($urandom_range(0, 3))
               0: send_read(kept_len);
               1: send_read((kept_len == 0) ? kept_len : LIMIT_W'(kept_len - 1));
               2: send_read(LIMIT_W'(MSG_BYTES));
               default: send_read(LIMIT_W'($urandom_range(0, MSG_BYTES)));
            endcase
         end else begin
            send_beat(ACT_NONE, pick_byte(), 1'($urandom), LIMIT_W'($urandom));
         end
         if ($urandom_range(0, 99) < 2)
            wait_drained();
      end
   endtask

   initial begin
      foreach (status_seen[i])
         status_seen[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct = 53;
      test_after_reset();
      test_short_messages();
      test_length_extremes();
      test_overwrite_oldest();
      test_unused_action();
      test_random_traffic(50);

      // Drain fully before swapping who idles.
      wait_drained();
      send_idle_pct = 53;
      recv_idle_pct = 24;
      test_random_traffic(50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(50);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      // Let any trailing copy finish and catch stray response beats.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d expected response beats never arrived", pending_results.size());
         error_count++;
      end
      $display("covered %0d request beats and %0d response beats in %0d cycles",
               beats_sent, beats_checked, cycle_count);
      $write("accepted %0d, dropped %0d, too long %0d, dequeued %0d, ",
             status_seen[ST_ACCEPTED], status_seen[ST_DROPPED], status_seen[ST_TOO_LONG],
             status_seen[ST_DEQUEUED]);
      $display("empty %0d, bytes %0d, refused %0d",
               status_seen[ST_EMPTY], status_seen[ST_BYTE], status_seen[ST_REFUSED]);
      if (error_count == 0) begin
         $display("overwriting_message_ring_top test passed");
      end else begin
         $display("overwriting_message_ring_top test failed");
      end
      $finish;
   end

endmodule
